[sv/sorted_set_insert_remove_macros.svh]
// Assertion macros for the sorted set block.
// Used by sorted_set_insert_remove, which checks its own logic; no other dependencies.
`ifndef SORTED_SET_INSERT_REMOVE_MACROS_SVH
`define SORTED_SET_INSERT_REMOVE_MACROS_SVH

`ifndef SYNTHESIS
`define SSIR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted set assertion failed");
`define SSIR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sorted set assertion failed");
`else
`define SSIR_ASSERT(label, prop)
`define SSIR_ASSERT_ALWAYS(label, prop)
`endif

`endif

[sv/ssir_pkg.sv]
// Shared types and constants for the sorted set block.
// Used by ssir_cell and sorted_set_insert_remove; depends on nothing.
package ssir_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int OCC_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_REM  = 2'd2
  } cell_cmd_t;

  // Broadcast control for every cell in the chain.
  typedef struct packed {
    logic      cmp_en;
    logic      strict;
    cell_cmd_t cmd;
  } cell_ctrl_t;

endpackage

[sv/ssir_cell.sv]
// One storage cell of the sorted chain: holds a value, compares it with the key
// and shifts toward either neighbor. Depends on ssir_pkg.
module ssir_cell (
  input  logic                              clk,
  input  ssir_pkg::cell_ctrl_t              ctrl,
  input  logic signed [ssir_pkg::DATA_W-1:0] cmp_key,
  input  logic signed [ssir_pkg::DATA_W-1:0] ins_key,
  input  logic                              occ,
  input  logic                              prev_flag,
  input  logic signed [ssir_pkg::DATA_W-1:0] prev_val,
  input  logic signed [ssir_pkg::DATA_W-1:0] next_val,
  output logic signed [ssir_pkg::DATA_W-1:0] val,
  output logic                              flag,
  output logic                              eq
);
  import ssir_pkg::*;

  // The flag marks a stored value that stays below the insertion point.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flag <= occ && (ctrl.strict ? (val <= cmp_key) : (val < cmp_key));
      eq   <= occ && (val == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_INS: begin
        if (!flag) begin
          val <= prev_flag ? ins_key : prev_val;
        end
      end
      CMD_REM: begin
        if (!flag) begin
          val <= next_val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/sorted_set_insert_remove.sv]
// Sorted set: each command is a compare, registered when the command is accepted, then a
// shift through the cell chain in the busy state; no command is taken until that shift
// is done. A waiting result does not block the next compare, only its shift.
// Synchronous active-high reset empties the store and drops any pending result.
// Depends on ssir_pkg, ssir_cell and sorted_set_insert_remove_macros.svh.
`include "sorted_set_insert_remove_macros.svh"
module sorted_set_insert_remove (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         opcode,
  input  logic signed [ssir_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [ssir_pkg::POS_W-1:0]         position,
  output logic [ssir_pkg::OCC_W-1:0]         occupancy
);
  import ssir_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  op_t                       op_r;
  logic signed [DATA_W-1:0]  key_r;
  status_t                   status_r, st_sel;
  logic [CNT_W-1:0]          pos_r, pos_sel, pos_enc;

  logic                      accept, apply, full, found;
  cell_ctrl_t                ctrl;
  cell_cmd_t                 cmd_sel;

  logic [CAPACITY-1:0]       occ, flag, eq, prev_flag, bnd;
  logic signed [DATA_W-1:0]  val [CAPACITY];

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The shift waits while the previous result is still held.
  assign apply    = (state == S_BUSY) && (!out_valid || !out_stall);
  assign full     = (count >= CNT_W'(CAPACITY));

  assign ctrl.cmp_en = accept;
  assign ctrl.strict = (op_t'(opcode) == OP_LOAD);
  assign ctrl.cmd    = apply ? cmd_sel : CMD_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count > CNT_W'(i));
    if (i == 0) begin : g_first
      assign prev_flag[i] = 1'b1;
    end else begin : g_rest
      assign prev_flag[i] = flag[i-1];
    end
    assign bnd[i] = prev_flag[i] && !flag[i];

    ssir_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cmp_key   (value),
      .ins_key   (key_r),
      .occ       (occ[i]),
      .prev_flag (prev_flag[i]),
      .prev_val  ((i == 0) ? val[0] : val[(i == 0) ? 0 : i-1]),
      .next_val  ((i == CAPACITY-1) ? val[i] : val[(i == CAPACITY-1) ? i : i+1]),
      .val       (val[i]),
      .flag      (flag[i]),
      .eq        (eq[i])
    );
  end

  assign found = |(bnd & eq);

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_enc = pos_enc | (bnd[i] ? CNT_W'(i) : '0);
    end
  end

  always_comb begin
    cmd_sel    = CMD_HOLD;
    st_sel     = ST_DONE;
    pos_sel    = '0;
    count_next = count;
    case (op_r)
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_LOAD: begin
        if (full) begin
          st_sel = ST_FULL;
        end else begin
          cmd_sel    = CMD_INS;
          pos_sel    = pos_enc;
          count_next = count + 1'b1;
        end
      end
      OP_INSERT: begin
        if (found) begin
          st_sel = ST_MISS;
        end else if (full) begin
          st_sel = ST_FULL;
        end else begin
          cmd_sel    = CMD_INS;
          pos_sel    = pos_enc;
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          cmd_sel    = CMD_REM;
          pos_sel    = pos_enc;
          count_next = count - 1'b1;
        end else begin
          st_sel = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (apply) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(opcode);
      key_r <= value;
    end
    if (apply) begin
      status_r  <= st_sel;
      pos_r     <= pos_sel;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign status   = status_r;
  assign position = POS_W'(pos_r);

  `SSIR_ASSERT(a_accept_to_busy, accept |=> (state == S_BUSY))
  `SSIR_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))
  `SSIR_ASSERT(a_flag_thermo, (state == S_BUSY) |-> ((flag & ~prev_flag) == '0))
  `SSIR_ASSERT(a_one_boundary, (state == S_BUSY) |-> $onehot0(bnd))
  `SSIR_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE) && !out_valid)

endmodule
